// ----- rtl/core/smpq_pkg.sv -----
// shared types and constants for the sorted min-priority queue
`default_nettype none

package smpq_pkg;

  // default sizes
  localparam int DEPTH_DEF       = 256;
  localparam int KEY_BITS_DEF    = 32;
  localparam int HANDLE_BITS_DEF = 10;

  // capacity register
  localparam int                CAP_BITS  = 9;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

  // request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } smpq_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } smpq_op_t;

  // position flags handed from a cell to its right neighbor
  typedef struct packed {
    logic le;     // occupied and new key <= stored key
    logic atpos;  // insert position is at or left of this cell
  } smpq_link_t;

endpackage

`default_nettype wire

// ----- rtl/core/smpq_cell.sv -----
// one storage cell of the sorted queue chain
`default_nettype none

module smpq_cell
  import smpq_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int CNT_W       = 9,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire                    clk,
  input  smpq_op_t               op,
  input  wire  [CNT_W-1:0]       count,
  input  wire  [KEY_BITS-1:0]    new_key,
  input  wire  [HANDLE_BITS-1:0] new_handle,
  input  smpq_link_t             left_link,
  input  wire  [KEY_BITS-1:0]    left_key,
  input  wire  [HANDLE_BITS-1:0] left_handle,
  input  wire  [KEY_BITS-1:0]    right_key,
  input  wire  [HANDLE_BITS-1:0] right_handle,
  output smpq_link_t             link,
  output logic [KEY_BITS-1:0]    key,
  output logic [HANDLE_BITS-1:0] handle
);

  logic [KEY_BITS-1:0]    key_r;
  logic [KEY_BITS-1:0]    key_nxt;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [HANDLE_BITS-1:0] handle_nxt;
  logic                   occ;
  logic                   gt;

  assign occ = (CNT_W'(IDX) < count);
  assign gt  = occ && (new_key < key_r);

  assign link.le    = occ && (new_key <= key_r);
  // keys are sorted, so le of the left neighbor puts the slot at or left of here
  assign link.atpos = left_link.le || gt || !occ;

  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    priority if (op.enq) begin
      if (left_link.atpos) begin
        key_nxt    = left_key;
        handle_nxt = left_handle;
      end else if (link.atpos) begin
        key_nxt    = new_key;
        handle_nxt = new_handle;
      end
    end else if (op.deq) begin
      key_nxt    = right_key;
      handle_nxt = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign key    = key_r;
  assign handle = handle_r;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_min_priority_queue_top.sv -----
// top level of the sorted min-priority queue: cell chain, count, capacity, result register
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall    | in_req_type, in_key_in, in_handle_in
//  out_    | output    | out_valid / out_stall  | out_status, out_key_out, out_handle_out,
//          |           |                        | out_count_out
//  cfg_    | input     | cfg_wr_en              | cfg_wr_data (capacity limit)
//
// one transaction per cycle while in_stall is low: every cell compares its key with the
// incoming key in the same cycle and the row shifts at the accepting edge; the result
// is loaded into the output register at that same edge.
// reset (rst_n low, synchronous) empties the queue and sets the capacity to 256;
// cell contents are not cleared.
// in_stall rises only while a result sits in the output register and out_stall is high.
`default_nettype none

module sorted_min_priority_queue_top
  import smpq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // request channel
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_req_type,
  input  wire  [KEY_BITS-1:0]    in_key_in,
  input  wire  [HANDLE_BITS-1:0] in_handle_in,
  // result channel
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [1:0]             out_status,
  output logic [KEY_BITS-1:0]    out_key_out,
  output logic [HANDLE_BITS-1:0] out_handle_out,
  output logic [CNT_W-1:0]       out_count_out,
  // capacity register
  input  wire                    cfg_wr_en,
  input  wire  [CAP_BITS-1:0]    cfg_wr_data
);

  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  // control state
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CAP_BITS-1:0] cap_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  // result payload register
  smpq_status_t           status_r;
  smpq_status_t           status_nxt;
  logic [KEY_BITS-1:0]    okey_r;
  logic [KEY_BITS-1:0]    okey_nxt;
  logic [HANDLE_BITS-1:0] ohandle_r;
  logic [HANDLE_BITS-1:0] ohandle_nxt;
  logic [CNT_W-1:0]       ocount_r;

  logic     accept;
  logic     full;
  logic     empty;
  smpq_op_t op;

  // cell row wiring
  logic [KEY_BITS-1:0]    cell_key    [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  smpq_link_t             cell_link   [DEPTH];

  // a result can be taken in while the previous one drains
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // capacity above depth behaves as depth
  assign full  = (count_r >= CNT_W'(DEPTH)) || (CMP_W'(count_r) >= CMP_W'(cap_r));
  assign empty = (count_r == '0);

  always_comb begin
    op            = '{enq: 1'b0, deq: 1'b0};
    count_nxt     = count_r;
    status_nxt    = status_r;
    okey_nxt      = okey_r;
    ohandle_nxt   = ohandle_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      okey_nxt      = '0;
      ohandle_nxt   = '0;
      if (in_req_type == REQ_ENQ) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          op.enq     = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          // head of the row is the smallest key
          status_nxt  = ST_OK;
          op.deq      = 1'b1;
          okey_nxt    = cell_key[0];
          ohandle_nxt = cell_handle[0];
          count_nxt   = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    okey_r    <= okey_nxt;
    ohandle_r <= ohandle_nxt;
    if (accept) begin
      ocount_r <= count_nxt;
    end
  end

  // on insert, cells past the slot take from the left; on removal, all from the right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    smpq_link_t             l_link;
    logic [KEY_BITS-1:0]    l_key;
    logic [HANDLE_BITS-1:0] l_handle;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;

    if (i == 0) begin : g_first
      assign l_link   = '{le: 1'b0, atpos: 1'b0};
      assign l_key    = in_key_in;
      assign l_handle = in_handle_in;
    end else begin : g_mid
      assign l_link   = cell_link[i-1];
      assign l_key    = cell_key[i-1];
      assign l_handle = cell_handle[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // slot beyond the last entry is never read after a removal
      assign r_key    = cell_key[i];
      assign r_handle = cell_handle[i];
    end else begin : g_inner
      assign r_key    = cell_key[i+1];
      assign r_handle = cell_handle[i+1];
    end

    smpq_cell #(
      .IDX         (i),
      .CNT_W       (CNT_W),
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk          (clk),
      .op           (op),
      .count        (count_r),
      .new_key      (in_key_in),
      .new_handle   (in_handle_in),
      .left_link    (l_link),
      .left_key     (l_key),
      .left_handle  (l_handle),
      .right_key    (r_key),
      .right_handle (r_handle),
      .link         (cell_link[i]),
      .key          (cell_key[i]),
      .handle       (cell_handle[i])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_key_out    = okey_r;
  assign out_handle_out = ohandle_r;
  assign out_count_out  = ocount_r;

endmodule

`default_nettype wire

// ----- rtl/core/smpq_chk.sv -----
// port-level checker for the sorted min-priority queue, bound to the top level
`default_nettype none

module smpq_chk
  import smpq_pkg::*;
#(
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int CNT_W       = 9
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire [1:0]             out_status,
  input wire [KEY_BITS-1:0]    out_key_out,
  input wire [HANDLE_BITS-1:0] out_handle_out,
  input wire [CNT_W-1:0]       out_count_out
);

  // stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_key_out) && $stable(out_handle_out) && $stable(out_count_out))
    else $error("stalled result changed");

  // input is held off only by a blocked result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without blocked result");

  // rejected transactions carry no entry
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_EMPTY) |->
      out_key_out == '0 && out_handle_out == '0)
    else $error("rejected result carries data");

  // empty rejection leaves an empty queue
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count_out == '0)
    else $error("empty rejection with nonzero count");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY)
    else $error("undefined status code");

endmodule

bind sorted_min_priority_queue_top smpq_chk #(
  .KEY_BITS    (KEY_BITS),
  .HANDLE_BITS (HANDLE_BITS),
  .CNT_W       (CNT_W)
) u_smpq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_key_out    (out_key_out),
  .out_handle_out (out_handle_out),
  .out_count_out  (out_count_out)
);

`default_nettype wire
